@@ sv/rspe_pkg.sv @@
// shared types, constants and gf(2^10) constant-multiply helper for the rs parity encoder
`default_nettype none

package rspe_pkg;

  localparam int SYM_W     = 10;
  localparam int NUM_PAR   = 8;
  localparam int BYTE_W    = 8;
  localparam int PAR_BITS  = SYM_W * NUM_PAR;
  localparam int PAR_BYTES = PAR_BITS / BYTE_W;
  localparam int BCNT_W    = $clog2(PAR_BYTES);

  typedef logic [SYM_W-1:0]    sym_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [PAR_BITS-1:0] par_vec_t;
  typedef logic [BCNT_W-1:0]   bcnt_t;

  // row b: mask of feedback bits whose xor gives product bit b
  typedef logic [0:SYM_W-1][SYM_W-1:0] coef_mat_t;

  // control handed to every cell of the chain
  typedef struct packed {
    logic adv;
    logic clr;
  } cell_ctrl_t;

  localparam coef_mat_t COEF_ROWS [NUM_PAR] = '{
    '{10'h216, 10'h02C, 10'h059, 10'h2A4, 10'h148, 10'h290, 10'h121, 10'h242, 10'h085, 10'h10B},
    '{10'h393, 10'h327, 10'h24E, 10'h30F, 10'h21E, 10'h03C, 10'h079, 10'h0F2, 10'h1E4, 10'h3C9},
    '{10'h2E0, 10'h1C1, 10'h382, 10'h1E5, 10'h3CB, 10'h397, 10'h32E, 10'h25C, 10'h0B8, 10'h170},
    '{10'h32E, 10'h25C, 10'h0B8, 10'h25E, 10'h0BC, 10'h179, 10'h2F2, 10'h1E5, 10'h3CB, 10'h397},
    '{10'h24B, 10'h097, 10'h12F, 10'h014, 10'h029, 10'h052, 10'h0A4, 10'h149, 10'h292, 10'h125},
    '{10'h015, 10'h02B, 10'h056, 10'h0B8, 10'h170, 10'h2E0, 10'h1C1, 10'h382, 10'h305, 10'h20A},
    '{10'h261, 10'h0C3, 10'h186, 10'h16C, 10'h2D9, 10'h1B3, 10'h366, 10'h2CC, 10'h198, 10'h330},
    '{10'h1FC, 10'h3F9, 10'h3F3, 10'h21B, 10'h037, 10'h06F, 10'h0DF, 10'h1BF, 10'h37F, 10'h2FE}
  };

  // constant multiply as an xor matrix, one parity tree per product bit
  function automatic sym_t gf_mul(input coef_mat_t m, input sym_t fb);
    sym_t r;
    for (int b = 0; b < SYM_W; b++) begin
      r[b] = ^(fb & m[b]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/rspe_ifs.sv @@
// valid/ready channel interfaces for the symbol input and the parity byte output
`default_nettype none

interface rspe_sym_if import rspe_pkg::*; ();
  logic valid;
  logic ready;
  sym_t data_symbol;
  logic block_end;

  modport source (output valid, output data_symbol, output block_end, input ready);
  modport sink   (input valid, input data_symbol, input block_end, output ready);
endinterface

interface rspe_byte_if import rspe_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t parity_byte;
  logic  last_byte;

  modport source (output valid, output parity_byte, output last_byte, input ready);
  modport sink   (input valid, input parity_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ sv/rspe_cell.sv @@
// one lfsr cell: a parity register, its constant multiplier and the neighbor xor
`default_nettype none

module rspe_cell import rspe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire coef_mat_t  coef,
  input  wire sym_t       fb,
  input  wire sym_t       prev,
  output sym_t            par_nxt,
  output sym_t            par_r
);

  assign par_nxt = gf_mul(coef, fb) ^ prev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r <= '0;
    end else if (ctrl.adv) begin
      par_r <= ctrl.clr ? '0 : par_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/rspe_ser.sv @@
// parity snapshot register and byte serializer
`default_nettype none

module rspe_ser import rspe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire par_vec_t load_data,
  output logic          free,
  rspe_byte_if.source   out_par
);

  par_vec_t snap_r;
  logic     vld_r;
  bcnt_t    cnt_r;
  logic     last;

  assign last                = (cnt_r == bcnt_t'(PAR_BYTES - 1));
  assign free                = !vld_r || (out_par.ready && last);
  assign out_par.valid       = vld_r;
  assign out_par.parity_byte = snap_r[PAR_BITS-1 -: BYTE_W];
  assign out_par.last_byte   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      cnt_r <= '0;
    end else if (vld_r && out_par.ready) begin
      cnt_r <= cnt_r + bcnt_t'(1);
      if (last) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r <= load_data;
    end else if (vld_r && out_par.ready) begin
      snap_r <= snap_r << BYTE_W;
    end
  end

endmodule

`default_nettype wire

@@ sv/rs_parity_encoder_gf1024_8sym.sv @@
// top level of the gf(2^10) reed-solomon parity encoder, eight parity symbols
//
//  channel   dir  handshake        payload
//  in_sym    in   valid / ready    data_symbol[9:0], block_end
//  out_par   out  valid / ready    parity_byte[7:0], last_byte
//
// one symbol per cycle if ready; the eight-cell lfsr chain updates in the accept cycle
// a block_end item loads the updated parity into the serializer and clears the chain,
// so the next block may start in the very next cycle
// the ten parity bytes leave one per cycle while out_par.ready is high
// a block_end item waits while the serializer still holds bytes of the previous block;
// ordinary symbols are never held back by the output side
// reset is synchronous, active low, and clears the chain and the serializer
`default_nettype none

module rs_parity_encoder_gf1024_8sym import rspe_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  rspe_sym_if.sink    in_sym,
  rspe_byte_if.source out_par
);

  sym_t       par_q   [NUM_PAR];
  sym_t       par_n   [NUM_PAR];
  sym_t       prev    [NUM_PAR];
  sym_t       fb;
  cell_ctrl_t ctrl;
  logic       ser_free;
  logic       accept;
  par_vec_t   snap;

  // a block end needs the serializer; plain symbols go straight in
  assign in_sym.ready = !in_sym.block_end || ser_free;
  assign accept       = in_sym.valid && in_sym.ready;

  // feedback taken from the top cell
  assign fb   = in_sym.data_symbol ^ par_q[NUM_PAR-1];
  assign ctrl = '{adv: accept, clr: in_sym.block_end};

  // cell 0 has no lower neighbor
  always_comb begin
    prev[0] = '0;
    for (int k = 1; k < NUM_PAR; k++) begin
      prev[k] = par_q[k-1];
    end
  end

  for (genvar k = 0; k < NUM_PAR; k++) begin : g_cell
    rspe_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .coef    (COEF_ROWS[k]),
      .fb      (fb),
      .prev    (prev[k]),
      .par_nxt (par_n[k]),
      .par_r   (par_q[k])
    );
    // top register lands in the high bits, msb first
    assign snap[k*SYM_W +: SYM_W] = par_n[k];
  end

  rspe_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && in_sym.block_end),
    .load_data (snap),
    .free      (ser_free),
    .out_par   (out_par)
  );

endmodule

`default_nettype wire

@@ sv/rspe_chk.sv @@
// port-level checker for the rs parity encoder, bound to the top level
`default_nettype none

module rspe_chk import rspe_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_block_end,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire byte_t out_parity_byte,
  input wire logic  out_last_byte
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parity_byte) && $stable(out_last_byte))
    else $error("output item changed while stalled");

  // parity appears the cycle after a block end
  a_blk_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_block_end |=> out_valid && !out_last_byte)
    else $error("no parity after block end");

  // output goes quiet after the last byte unless a new block ended
  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_byte && !(in_acc && in_block_end) |=> !out_valid)
    else $error("output valid after last byte");

  // a block end never overruns bytes still pending
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_block_end && out_valid && !(out_acc && out_last_byte)))
    else $error("block end accepted while parity pending");

endmodule

bind rs_parity_encoder_gf1024_8sym rspe_chk u_rspe_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_sym.valid),
  .in_ready        (in_sym.ready),
  .in_block_end    (in_sym.block_end),
  .out_valid       (out_par.valid),
  .out_ready       (out_par.ready),
  .out_parity_byte (out_par.parity_byte),
  .out_last_byte   (out_par.last_byte)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the gf(2^10) reed-solomon parity encoder, eight parity symbols

module tb_top;
  import rspe_pkg::*;

  // generator taps, row b of product k: feedback bits whose xor gives product bit b
  localparam logic [9:0] GEN_TAPS [8][10] = '{
    '{10'h216, 10'h02C, 10'h059, 10'h2A4, 10'h148, 10'h290, 10'h121, 10'h242, 10'h085, 10'h10B},
    '{10'h393, 10'h327, 10'h24E, 10'h30F, 10'h21E, 10'h03C, 10'h079, 10'h0F2, 10'h1E4, 10'h3C9},
    '{10'h2E0, 10'h1C1, 10'h382, 10'h1E5, 10'h3CB, 10'h397, 10'h32E, 10'h25C, 10'h0B8, 10'h170},
    '{10'h32E, 10'h25C, 10'h0B8, 10'h25E, 10'h0BC, 10'h179, 10'h2F2, 10'h1E5, 10'h3CB, 10'h397},
    '{10'h24B, 10'h097, 10'h12F, 10'h014, 10'h029, 10'h052, 10'h0A4, 10'h149, 10'h292, 10'h125},
    '{10'h015, 10'h02B, 10'h056, 10'h0B8, 10'h170, 10'h2E0, 10'h1C1, 10'h382, 10'h305, 10'h20A},
    '{10'h261, 10'h0C3, 10'h186, 10'h16C, 10'h2D9, 10'h1B3, 10'h366, 10'h2CC, 10'h198, 10'h330},
    '{10'h1FC, 10'h3F9, 10'h3F3, 10'h21B, 10'h037, 10'h06F, 10'h0DF, 10'h1BF, 10'h37F, 10'h2FE}
  };

  localparam int RANDOM_ITEMS = 256;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 24;

  // lfsr model of the encoder plus the queue of parity bytes still owed
  class parity_board;
    typedef struct {
      logic [7:0] value;
      logic       tail;
    } par_item_t;

    logic [9:0] lfsr_q [8];
    par_item_t  owed_q [$];
    int         errors;

    function new();
      clear_lfsr();
      errors = 0;
    endfunction

    function void clear_lfsr();
      foreach (lfsr_q[k]) lfsr_q[k] = '0;
    endfunction

    function logic [9:0] mul_tap(int k, logic [9:0] fb);
      logic [9:0] r;
      for (int b = 0; b < 10; b++) r[b] = ^(fb & GEN_TAPS[k][b]);
      return r;
    endfunction

    // one accepted symbol: shift the lfsr, and on block end owe ten bytes
    function void note_symbol(logic [9:0] sym, logic blk_end);
      logic [9:0] fb;
      logic [9:0] nxt [8];
      logic [79:0] flat;
      par_item_t it;
      fb = sym ^ lfsr_q[7];
      nxt[0] = mul_tap(0, fb);
      for (int k = 1; k < 8; k++) nxt[k] = mul_tap(k, fb) ^ lfsr_q[k-1];
      lfsr_q = nxt;
      if (blk_end) begin
        // register 7 ends up in the top bits, each register msb first
        for (int k = 0; k < 8; k++) flat[k*10 +: 10] = lfsr_q[k];
        for (int i = 0; i < 10; i++) begin
          it.value = flat[79 - 8*i -: 8];
          it.tail  = (i == 9);
          owed_q.push_back(it);
        end
        clear_lfsr();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_byte(logic [7:0] value, logic tail);
      par_item_t it;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected parity item %02h last %0b", value, tail));
        return;
      end
      it = owed_q.pop_front();
      if (value !== it.value)
        report($sformatf("parity_byte %02h, expected %02h", value, it.value));
      if (tail !== it.tail)
        report($sformatf("last_byte %0b, expected %0b", tail, it.tail));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rspe_sym_if  sym_if ();
  rspe_byte_if par_if ();

  rs_parity_encoder_gf1024_8sym dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_sym  (sym_if),
    .out_par (par_if)
  );

  parity_board board = new();

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs; far above the slowest legal run
  initial begin
    #5000000;
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: checks every accepted item, then picks ready from a stall pattern
  // that switches between always ready, coin flip and mostly stalled stretches
  int rx_left = 0;
  int rx_mode = 0;

  always @(posedge clk) begin
    if (rst_n && par_if.valid && par_if.ready)
      board.check_byte(par_if.parity_byte, par_if.last_byte);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: begin
        par_if.ready <= 1'b1;
      end
      1: begin
        par_if.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        par_if.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;

  task send_symbol(logic [9:0] sym, logic blk_end);
    if (burst_left == 0) begin
      sym_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst so that back-to-back streams get covered
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    sym_if.valid       <= 1'b1;
    sym_if.data_symbol <= sym;
    sym_if.block_end   <= blk_end;
    @(posedge clk);
    while (!sym_if.ready) @(posedge clk);
    board.note_symbol(sym, blk_end);
  endtask

  // hold the sender off until every owed parity item has come out
  task drain_pause();
    sym_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function logic [9:0] pick_symbol();
    case ($urandom_range(0, 9))
      0:       return 10'h000;
      1:       return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int sent;
    int blk_len;
    int guard;
    bit drained_mid;

    sym_if.valid       <= 1'b0;
    sym_if.data_symbol <= '0;
    sym_if.block_end   <= 1'b0;
    rst_n              <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all-zero block gives all-zero parity
    send_symbol(10'h000, 1'b1);
    // single max symbol, then a block of max symbols
    send_symbol(10'h3FF, 1'b1);
    send_symbol(10'h3FF, 1'b0);
    send_symbol(10'h3FF, 1'b0);
    send_symbol(10'h3FF, 1'b1);
    // walking one through every symbol bit
    for (int i = 0; i < 10; i++) send_symbol(10'(1 << i), (i == 9));
    // alternating bit patterns
    send_symbol(10'h155, 1'b0);
    send_symbol(10'h2AA, 1'b1);
    // back-to-back block ends, the later ones must wait for the serializer
    burst_left = 8;
    send_symbol(10'h001, 1'b1);
    send_symbol(10'h200, 1'b1);
    send_symbol(10'h3FF, 1'b1);
    drain_pause();

    // random blocks, mostly short, some long
    sent = 0;
    drained_mid = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      blk_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (int i = 0; i < blk_len; i++) send_symbol(pick_symbol(), (i == blk_len - 1));
      sent += blk_len;
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        drain_pause();
        drained_mid = 1'b1;
      end
    end
    sym_if.valid <= 1'b0;

    // wait for the last parity items, then watch a quiet tail for strays
    guard = 0;
    while (board.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (board.pending() == 0) repeat (TAIL_CYCLES) @(posedge clk);

    if (board.pending() == 0 && board.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rspe_pkg.sv
sv/rspe_ifs.sv
sv/rspe_cell.sv
sv/rspe_ser.sv
sv/rs_parity_encoder_gf1024_8sym.sv
sv/rspe_chk.sv
dv/tb_top.sv
